### design/mtcrc_pkg.sv
// Shared types, codes and helper functions for the meter telegram CRC checker.
// No dependencies; every other design file imports this package.
package mtcrc_pkg;

    localparam int BYTE_W   = 8;
    localparam int CRC_W    = 16;
    localparam int LEN_W    = 12;
    localparam int STATUS_W = 2;
    localparam int DIGIT_W  = 3;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'h0000;
    localparam logic [LEN_W-1:0]  MAX_LENGTH_RESET = 12'd1500;
    localparam logic [DIGIT_W-1:0] CRC_DIGITS = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_START = 8'h2F;  // '/'
    localparam logic [BYTE_W-1:0] CHAR_END   = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;  // '\n'

    // Register index, taken from paddr[2]
    localparam logic CFG_IDX_MAX_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_BODY  = 2'd1,
        PH_FIELD = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID     = 2'd0,
        ST_MISMATCH  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [CRC_W-1:0]   computed_crc;
        logic [CRC_W-1:0]   received_crc;
        logic [LEN_W-1:0]   telegram_length;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_digit_t;

    // Reflected CRC-16 over one byte, one bit per step.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // ASCII hex digit of either case.
    function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_digit_t d;
        d.is_hex = 1'b0;
        d.value  = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.is_hex = 1'b1;
            d.value  = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d.is_hex = 1'b1;
            d.value  = c[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage

### design/mtcrc_cfg.sv
// APB register block of the meter telegram CRC checker: holds max_length.
// Depends on mtcrc_pkg.
module mtcrc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mtcrc_pkg::APB_AW-1:0] paddr,
    input  logic [mtcrc_pkg::APB_DW-1:0] pwdata,
    output logic [mtcrc_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output logic [mtcrc_pkg::LEN_W-1:0]  max_length
);
    import mtcrc_pkg::*;

    logic [LEN_W-1:0] max_length_reg;
    logic [LEN_W-1:0] max_length_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        max_length_next = max_length_reg;
        if (wr_en && paddr[2] == CFG_IDX_MAX_LENGTH) begin
            max_length_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAX_LENGTH_RESET;
        end else begin
            max_length_reg <= max_length_next;
        end
    end

    // Unmapped addresses read as zero
    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_IDX_MAX_LENGTH) begin
            prdata = {{(APB_DW-LEN_W){1'b0}}, max_length_reg};
        end
    end

    assign max_length = max_length_reg;

endmodule

### design/mtcrc_frame.sv
// Telegram framing, CRC accumulation and sent-CRC parsing for one byte per cycle while byte_en is high.
// Depends on mtcrc_pkg.
module mtcrc_frame (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_en,
    input  logic [mtcrc_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [mtcrc_pkg::LEN_W-1:0]   max_length,
    output logic                          res_valid,
    output mtcrc_pkg::result_t            res
);
    import mtcrc_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [CRC_W-1:0]   crc_reg, crc_next;
    logic [LEN_W-1:0]   count_reg, count_next;
    logic [CRC_W-1:0]   sent_reg, sent_next;
    logic [DIGIT_W-1:0] digits_reg, digits_next;
    logic               hex_err_reg, hex_err_next;
    hex_digit_t         hd;
    logic               at_limit;

    assign hd       = hex_decode(rx_byte);
    assign at_limit = count_reg >= max_length;

    always_comb begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        count_next   = count_reg;
        sent_next    = sent_reg;
        digits_next  = digits_reg;
        hex_err_next = hex_err_reg;
        res_valid    = 1'b0;
        res.status          = ST_TOO_LONG;
        res.computed_crc    = crc_reg;
        res.received_crc    = sent_reg;
        res.telegram_length = count_reg;

        if (byte_en) begin
            unique case (phase_reg)
                PH_BODY, PH_FIELD: begin
                    if (at_limit) begin
                        // abort with the state as it stood, drop this byte
                        res_valid  = 1'b1;
                        phase_next = PH_HUNT;
                    end else begin
                        count_next = count_reg + 1'b1;
                        if (phase_reg == PH_BODY) begin
                            crc_next = crc16_byte(crc_reg, rx_byte);
                            if (rx_byte == CHAR_END) begin
                                phase_next = PH_FIELD;
                            end
                        end else if (rx_byte == CHAR_LF) begin
                            res_valid  = 1'b1;
                            phase_next = PH_HUNT;
                            res.telegram_length = count_next;
                            if (hex_err_reg || digits_reg < CRC_DIGITS) begin
                                res.status = ST_MALFORMED;
                            end else if (sent_reg == crc_reg) begin
                                res.status = ST_VALID;
                            end else begin
                                res.status = ST_MISMATCH;
                            end
                        end else if (digits_reg < CRC_DIGITS) begin
                            digits_next = digits_reg + 1'b1;
                            if (hd.is_hex) begin
                                sent_next = {sent_reg[CRC_W-5:0], hd.value};
                            end else begin
                                hex_err_next = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    if (rx_byte == CHAR_START) begin
                        crc_next     = CRC_INIT;
                        count_next   = '0;
                        sent_next    = '0;
                        digits_next  = '0;
                        hex_err_next = 1'b0;
                        if (max_length == '0) begin
                            res_valid           = 1'b1;
                            res.computed_crc    = CRC_INIT;
                            res.received_crc    = '0;
                            res.telegram_length = '0;
                        end else begin
                            crc_next   = crc16_byte(CRC_INIT, rx_byte);
                            count_next = {{(LEN_W-1){1'b0}}, 1'b1};
                            phase_next = PH_BODY;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= CRC_INIT;
            count_reg   <= '0;
            sent_reg    <= '0;
            digits_reg  <= '0;
            hex_err_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            sent_reg    <= sent_next;
            digits_reg  <= digits_next;
            hex_err_reg <= hex_err_next;
        end
    end

endmodule

### design/meter_telegram_crc_checker_top.sv
// Top level of the meter telegram CRC checker: input register, framing logic,
// result register and APB configuration. Depends on mtcrc_pkg, mtcrc_cfg, mtcrc_frame.

// The block watches a meter's serial byte stream (one byte per item on the s_
// channel), skips everything until a '/' and then runs a reflected CRC-16
// (poly 0xA001, init 0) over every byte from the '/' through the '!'. The next four
// characters are read as the sent CRC in hex (either case), and the '\n' that
// follows closes the telegram with one result item on the m_ channel: status
// (0 valid, 1 CRC mismatch, 2 malformed or short CRC field, 3 too long), both
// CRCs and the byte count from '/' on. A byte that arrives while the count
// already equals max_length aborts the telegram with status 3 and is dropped;
// the block then hunts for '/' again. Bytes that close nothing give no result.
// Throughput is one item per clock while m_tready keeps the output register
// moving: a byte is taken into an input register, the framing and CRC logic
// handles it as it leaves that register and writes any result into the output
// register, which drives m_tvalid. A result waiting on m_tready stalls the byte
// in the input register; an empty input register still takes one more item.
// Change max_length (APB, address 0) only while no telegram is in progress.
module meter_telegram_crc_checker_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input bytes
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] status, [17:2] computed_crc, [33:18] received_crc,
    // [45:34] telegram_length, [47:46] zero
    output logic [47:0]                  m_tdata,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mtcrc_pkg::APB_AW-1:0] paddr,
    input  logic [mtcrc_pkg::APB_DW-1:0] pwdata,
    output logic [mtcrc_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import mtcrc_pkg::*;

    localparam int RES_W = $bits(result_t);

    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg;
    logic               advance;
    logic               fire;
    logic               s_accept;
    logic [LEN_W-1:0]   max_length;
    logic               res_valid;
    result_t            res;

    mtcrc_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .max_length (max_length)
    );

    // The output register moves when empty or being taken; hold everything otherwise.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
    end

    mtcrc_frame u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (fire),
        .rx_byte    (in_byte_reg),
        .max_length (max_length),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Load a result only when the processed byte produced one.
    assign out_valid_next = advance ? (fire && res_valid) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(48-RES_W){1'b0}},
                       out_res_reg.telegram_length,
                       out_res_reg.received_crc,
                       out_res_reg.computed_crc,
                       out_res_reg.status};

    // A valid status only comes with matching CRCs.
    a_valid_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.status == ST_VALID)
            |-> (out_res_reg.computed_crc == out_res_reg.received_crc))
        else $error("valid status with differing CRCs");

    // A closed telegram holds at least the start mark, end mark and line feed.
    a_close_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.status != ST_TOO_LONG)
            |-> (out_res_reg.telegram_length >= 12'd3))
        else $error("closed telegram shorter than three bytes");

    // A buffered byte is never lost while the result side stalls.
    a_hold_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost or changed");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for meter_telegram_crc_checker_top: random and directed
// byte streams on s_, results checked on m_. Depends on mtcrc_pkg and the design.
module tb;
    import mtcrc_pkg::*;

    // Byte of the optional carriage return before the closing line feed
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Shapes of generated telegrams
    localparam int FORM_VALID     = 0;  // correct CRC, "!XXXX\n"
    localparam int FORM_VALID_CR  = 1;  // correct CRC, "!XXXX\r\n"
    localparam int FORM_MISMATCH  = 2;  // one bit of the sent CRC flipped
    localparam int FORM_MALFORMED = 3;  // one non-hex character among the four
    localparam int FORM_SHORT     = 4;  // fewer than four digits before '\n'
    localparam int FORM_EXTRA     = 5;  // stray characters after the digits
    localparam int FORM_CUT       = 6;  // body without end mark, never closed

    localparam logic [APB_AW-1:0] ADDR_MAX_LENGTH = {CFG_IDX_MAX_LENGTH, 2'b00};
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    // Predicts telegram results from accepted bytes and checks result items.
    class telegram_scoreboard;
        phase_t      phase;
        logic [15:0] crc_run;
        logic [11:0] byte_count;
        logic [11:0] max_len;
        logic [15:0] sent_crc;
        int unsigned digits;
        bit          field_bad;
        result_t     pending[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned per_status[4];

        function new();
            phase      = PH_HUNT;
            crc_run    = CRC_INIT;
            byte_count = '0;
            max_len    = MAX_LENGTH_RESET;
            sent_crc   = '0;
            digits     = 0;
            field_bad  = 1'b0;
            errors     = 0;
            checked    = 0;
            foreach (per_status[i]) per_status[i] = 0;
        endfunction

        static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            return c;
        endfunction

        // Value of an ASCII hex digit, or -1 for anything else
        static function int hex_nibble(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return int'(ch - "0");
            if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
            if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
            return -1;
        endfunction

        function void log_failure(string msg);
            errors++;
            if (errors <= REPORT_LIMIT) $display("%s", msg);
        endfunction

        function void push_result(status_t st);
            result_t r;
            r.status          = st;
            r.computed_crc    = crc_run;
            r.received_crc    = sent_crc;
            r.telegram_length = byte_count;
            pending.push_back(r);
        endfunction

        function void note_byte(logic [7:0] c);
            int v;
            if (phase != PH_BODY && phase != PH_FIELD) begin
                phase = PH_HUNT;
                if (c != CHAR_START) return;
                crc_run    = CRC_INIT;
                byte_count = '0;
                sent_crc   = '0;
                digits     = 0;
                field_bad  = 1'b0;
                if (byte_count >= max_len) begin
                    push_result(ST_TOO_LONG);
                    return;
                end
                crc_run    = crc_update(CRC_INIT, c);
                byte_count = 12'd1;
                phase      = PH_BODY;
                return;
            end
            // abort: the byte that would overflow is dropped
            if (byte_count >= max_len) begin
                push_result(ST_TOO_LONG);
                phase = PH_HUNT;
                return;
            end
            byte_count = byte_count + 12'd1;
            if (phase == PH_BODY) begin
                crc_run = crc_update(crc_run, c);
                if (c == CHAR_END) phase = PH_FIELD;
                return;
            end
            if (c == CHAR_LF) begin
                if (field_bad || digits < 4) push_result(ST_MALFORMED);
                else if (sent_crc == crc_run) push_result(ST_VALID);
                else push_result(ST_MISMATCH);
                phase = PH_HUNT;
                return;
            end
            // only the first four field characters matter
            if (digits < 4) begin
                v = hex_nibble(c);
                if (v < 0) field_bad = 1'b1;
                else sent_crc = {sent_crc[11:0], 4'(v)};
                digits++;
            end
        endfunction

        function void check_result(logic [47:0] d);
            result_t want;
            status_t got_st;
            got_st = status_t'(d[1:0]);
            if (pending.size() == 0) begin
                log_failure($sformatf({"%0t: result with nothing pending: ",
                                       "status %0d crc %h sent %h len %0d"},
                                      $time, got_st, d[17:2], d[33:18], d[45:34]));
                return;
            end
            want = pending.pop_front();
            checked++;
            per_status[want.status]++;
            if (got_st !== want.status || d[17:2] !== want.computed_crc ||
                d[33:18] !== want.received_crc || d[45:34] !== want.telegram_length ||
                d[47:46] !== 2'b00) begin
                log_failure($sformatf({"%0t: mismatch: want status %0d crc %h sent %h len %0d, ",
                                       "got status %0d crc %h sent %h len %0d pad %b"},
                                      $time, want.status, want.computed_crc, want.received_crc,
                                      want.telegram_length, got_st, d[17:2], d[33:18],
                                      d[45:34], d[47:46]));
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;   // [7:0] rx_byte
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [1:0] status, [17:2] computed_crc, [33:18] received_crc,
    // [45:34] telegram_length, [47:46] zero
    logic [47:0]         m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [APB_AW-1:0]   paddr    = '0;
    logic [APB_DW-1:0]   pwdata   = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    telegram_scoreboard  sb;
    int unsigned         cycle_count  = 0;
    int unsigned         bytes_driven = 0;
    int unsigned         settings_used = 1;
    int                  sink_hold    = 0;
    bit                  sink_calm    = 1'b0;
    bit                  src_calm     = 1'b0;

    meter_telegram_crc_checker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Hex digit of either case
    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) return "0" + v;
        return ($urandom_range(0, 1) ? "a" : "A") + (v - 4'd10);
    endfunction

    // Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.pending.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side backpressure: random stalls, with calm stretches now and then.
    always @(posedge aclk) begin
        if (cycle_count[6:0] == 0) sink_calm <= ($urandom_range(0, 3) == 0);
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end else begin
            sink_hold <= sink_calm ? 0 : idle_len();
            m_tready  <= 1'b1;
        end
    end

    // Sample both channels at the edge: predict on accepted bytes, check results.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Present one byte after an optional gap and hold it until accepted.
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = src_calm ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_driven++;
    endtask

    // Build one telegram of the given shape: '/', body, '!', CRC field, '\n'.
    task automatic send_telegram(int body_len, int form);
        logic [7:0]  ch;
        logic [15:0] crc;
        logic [15:0] field_val;
        int          n_digits;
        int          bad_pos;
        crc = telegram_scoreboard::crc_update(CRC_INIT, CHAR_START);
        send_byte(CHAR_START);
        for (int i = 0; i < body_len; i++) begin
            do ch = 8'($urandom_range(0, 255)); while (ch == CHAR_END);
            crc = telegram_scoreboard::crc_update(crc, ch);
            send_byte(ch);
        end
        if (form == FORM_CUT) return;
        crc = telegram_scoreboard::crc_update(crc, CHAR_END);
        send_byte(CHAR_END);
        field_val = (form == FORM_MISMATCH) ? crc ^ (16'h1 << $urandom_range(0, 15)) : crc;
        n_digits  = (form == FORM_SHORT) ? $urandom_range(0, 3) : 4;
        bad_pos   = $urandom_range(0, 3);
        for (int i = 0; i < n_digits; i++) begin
            ch = hex_char(field_val[15 - 4*i -: 4]);
            if (form == FORM_MALFORMED && i == bad_pos) begin
                do ch = 8'($urandom_range(0, 255));
                while (telegram_scoreboard::hex_nibble(ch) >= 0 || ch == CHAR_LF);
            end
            send_byte(ch);
        end
        if (form == FORM_VALID_CR) send_byte(CHAR_CR);
        if (form == FORM_EXTRA) begin
            repeat ($urandom_range(1, 3)) begin
                do ch = 8'($urandom_range(0, 255)); while (ch == CHAR_LF);
                send_byte(ch);
            end
        end
        send_byte(CHAR_LF);
    endtask

    // Random traffic: mostly well-formed telegrams, some broken ones and noise.
    task automatic random_traffic(int n_bytes);
        int unsigned stop_at;
        int          r;
        int          form;
        int          body_len;
        stop_at = bytes_driven + n_bytes;
        while (bytes_driven < stop_at) begin
            src_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            r = $urandom_range(0, 99);
            if (r < 40)      form = FORM_VALID;
            else if (r < 65) form = FORM_VALID_CR;
            else if (r < 77) form = FORM_MISMATCH;
            else if (r < 85) form = FORM_MALFORMED;
            else if (r < 91) form = FORM_SHORT;
            else if (r < 96) form = FORM_EXTRA;
            else             form = FORM_CUT;
            body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200)
                                                   : $urandom_range(0, 40);
            send_telegram(body_len, form);
        end
        src_calm = 1'b0;
    endtask

    // Wait for every pending result, then let the pipeline empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Close any open telegram, go idle and write a new length limit.
    task automatic set_max_length(logic [11:0] limit);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        if (sb.phase == PH_BODY) begin
            send_byte(CHAR_END);
            send_byte(CHAR_LF);
        end else if (sb.phase == PH_FIELD) begin
            send_byte(CHAR_LF);
        end
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LENGTH;
        pwdata  <= {20'h0, limit};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.max_len = limit;
        settings_used++;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: noise with all bit values, then one telegram of each shape but the cut one.
        src_calm = 1'b1;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_telegram(0, FORM_VALID);
        send_telegram(0, FORM_VALID_CR);
        send_telegram(0, FORM_MISMATCH);
        send_telegram(0, FORM_MALFORMED);
        send_telegram(0, FORM_SHORT);
        send_telegram(1, FORM_EXTRA);
        // a second start mark inside a telegram is plain data
        send_byte(CHAR_START);
        send_byte(CHAR_START);
        send_byte(CHAR_END);
        send_byte(CHAR_LF);
        src_calm = 1'b0;
        random_traffic(150);

        // Shortest limit: exact fit, overflow on the '\n', overflow on a '/'.
        set_max_length(12'd16);
        send_telegram(9, FORM_VALID);
        send_telegram(10, FORM_VALID);
        send_byte(CHAR_START);
        repeat (15) send_byte("x");
        send_byte(CHAR_START);
        send_byte(CHAR_END);
        send_byte(CHAR_LF);
        random_traffic(150);

        // Longest limit: no random telegram comes near it.
        set_max_length(12'd4095);
        random_traffic(150);

        // Small random limit, so aborts are common in random traffic.
        set_max_length(12'($urandom_range(16, 64)));
        random_traffic(150);

        set_max_length(12'($urandom_range(65, 4094)));
        random_traffic(150);

        // Back to the reset value.
        set_max_length(MAX_LENGTH_RESET);
        random_traffic(200);

        drain();
        if (sb.pending.size() != 0)
            sb.log_failure($sformatf("%0d results never arrived", sb.pending.size()));

        $display("Drove %0d bytes under %0d length limits; checked %0d telegram results",
                 bytes_driven, settings_used, sb.checked);
        $display("  valid %0d, CRC mismatch %0d, malformed field %0d, too long %0d, failures %0d",
                 sb.per_status[ST_VALID], sb.per_status[ST_MISMATCH],
                 sb.per_status[ST_MALFORMED], sb.per_status[ST_TOO_LONG], sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
